@@ sv/dbd_pkg.sv @@
`default_nettype none
package dbd_pkg;

   localparam int DayW   = 5;
   localparam int MonW   = 4;
   localparam int YearW  = 14;
   localparam int CountW = 22;
   localparam int StatW  = 2;
   localparam int OrdW   = 23;
   localparam int ReqW   = 48;
   localparam int RspW   = 24;
   localparam int MaxYear = 9999;

   // floor(x / 25) as (x * Recip25) >> Recip25Shift, exact for x below 43690
   localparam int Recip25      = 5243;
   localparam int Recip25Shift = 17;

   typedef enum logic [StatW-1:0] {
      STAT_OK      = 2'd0,
      STAT_ORDER   = 2'd1,
      STAT_INVALID = 2'd2
   } dbd_status_type;

   typedef struct packed {
      logic            ok;
      logic [OrdW-1:0] ord;
   } dbd_ord_type;

   // days before the start of a march-based month, 0 is march
   function automatic logic [8:0] month_offset(input logic [MonW-1:0] mm);
      logic [8:0] r;
      begin
         case (mm)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
         endcase
         return r;
      end
   endfunction

   // month length outside a leap year
   function automatic logic [DayW-1:0] month_length(input logic [MonW-1:0] m);
      logic [DayW-1:0] r;
      begin
         case (m)
            4'd2:    r = 5'd28;
            4'd4:    r = 5'd30;
            4'd6:    r = 5'd30;
            4'd9:    r = 5'd30;
            4'd11:   r = 5'd30;
            default: r = 5'd31;
         endcase
         return r;
      end
   endfunction

endpackage
`default_nettype wire

@@ sv/dbd_ordinal.sv @@
`default_nettype none
module dbd_ordinal
   import dbd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             adv,
   input  wire logic [DayW-1:0]  day,
   input  wire logic [MonW-1:0]  month,
   input  wire logic [YearW-1:0] year,
   output dbd_ord_type           ord_out
);

   localparam int YyW = YearW + 1;
   localparam int PW  = (YyW - 2) + 13;
   localparam int PyW = (YearW - 2) + 13;

   // stage a
   logic [YyW-1:0]   a_yy_ff, a_yy_in;
   logic [MonW-1:0]  a_mm_ff, a_mm_in;
   logic [DayW-1:0]  a_day_ff;
   logic [PW-1:0]    a_p_ff, a_p_in;
   logic [YearW-3:0] a_y4_ff;
   logic [PyW-1:0]   a_py_ff, a_py_in;
   logic             a_y4z_ff, a_chk_ff, a_chk_in, a_feb_ff;
   logic [DayW-1:0]  a_len_ff;

   // stage b
   logic [OrdW-1:0]  b_yd_ff, b_yd_in;
   logic [8:0]       b_md_ff, b_md_in;
   logic             b_ok_ff, b_ok_in;

   // stage c
   logic [OrdW-1:0]  c_ord_ff;
   logic             c_ok_ff;

   logic [7:0]       q_yy, q_y;
   logic [12:0]      q_y25;
   logic             y100z, leap;
   logic [DayW:0]    lim;

   always_comb begin
      a_yy_in = YyW'(year) + YyW'(400);
      if (month <= MonW'(2)) begin
         a_yy_in = a_yy_in - YyW'(1);
         a_mm_in = month + MonW'(9);
      end else begin
         a_mm_in = month - MonW'(3);
      end
      a_p_in   = PW'(a_yy_in[YyW-1:2]) * PW'(Recip25);
      a_py_in  = PyW'(year[YearW-1:2]) * PyW'(Recip25);
      a_chk_in = (year <= YearW'(MaxYear)) && (month >= MonW'(1)) &&
                 (month <= MonW'(12)) && (day != '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_yy_ff  <= a_yy_in;
         a_mm_ff  <= a_mm_in;
         a_day_ff <= day;
         a_p_ff   <= a_p_in;
         a_y4_ff  <= year[YearW-1:2];
         a_py_ff  <= a_py_in;
         a_y4z_ff <= (year[1:0] == 2'd0);
         a_chk_ff <= a_chk_in;
         a_feb_ff <= (month == MonW'(2));
         a_len_ff <= month_length(month);
      end
   end

   always_comb begin
      q_yy  = a_p_ff[Recip25Shift +: 8];
      q_y   = a_py_ff[Recip25Shift +: 8];
      q_y25 = 13'(q_y) * 13'd25;
      y100z = a_y4z_ff && (13'(a_y4_ff) == q_y25);
      leap  = a_y4z_ff && (!y100z || (q_y[1:0] == 2'd0));
      lim   = (DayW+1)'(a_len_ff) + (DayW+1)'(a_feb_ff && leap);
      b_ok_in = a_chk_ff && ((DayW+1)'(a_day_ff) <= lim);
      b_yd_in = OrdW'(a_yy_ff) * OrdW'(365) + OrdW'(a_yy_ff[YyW-1:2])
              - OrdW'(q_yy) + OrdW'(q_yy[7:2]);
      b_md_in = month_offset(a_mm_ff) + 9'(a_day_ff) - 9'd1;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_yd_ff  <= b_yd_in;
         b_md_ff  <= b_md_in;
         b_ok_ff  <= b_ok_in;
         c_ord_ff <= b_yd_ff + OrdW'(b_md_ff);
         c_ok_ff  <= b_ok_ff;
      end
   end

   assign ord_out.ok  = c_ok_ff;
   assign ord_out.ord = c_ord_ff;

endmodule
`default_nettype wire

@@ sv/days_between_dates_core.sv @@
// throughput: one beat per cycle; the four-stage pipeline (three date stages
// per date, then compare and subtract into the output register) stalls as a
// whole only while a finished rsp beat waits on rsp_tready
// reset: synchronous, clears all valid bits; no other state
`default_nettype none
module days_between_dates_core
   import dbd_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   // start_day, start_month, start_year, end_day, end_month, end_year, 2 zero bits
   input  wire logic [ReqW-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   // day_count, status
   output logic [RspW-1:0]      rsp_tdata
);

   localparam int Stages = 3;

   logic              adv;
   logic [Stages-1:0] v_ff, v_in;
   logic              rsp_v_ff;
   logic [CountW-1:0] cnt_ff, cnt_in;
   dbd_status_type    stat_ff, stat_in;
   dbd_ord_type       ord_s, ord_e;
   logic [OrdW-1:0]   diff;

   assign adv        = !rsp_v_ff || rsp_tready;
   assign req_tready = adv;

   dbd_ordinal u_start (
      .clock   (clock),
      .adv     (adv),
      .day     (req_tdata[4:0]),
      .month   (req_tdata[8:5]),
      .year    (req_tdata[22:9]),
      .ord_out (ord_s)
   );

   dbd_ordinal u_end (
      .clock   (clock),
      .adv     (adv),
      .day     (req_tdata[27:23]),
      .month   (req_tdata[31:28]),
      .year    (req_tdata[45:32]),
      .ord_out (ord_e)
   );

   always_comb begin
      v_in   = {v_ff[Stages-2:0], req_tvalid};
      diff   = ord_e.ord - ord_s.ord;
      cnt_in = '0;
      if (!ord_s.ok || !ord_e.ok) begin
         stat_in = STAT_INVALID;
      end else if (ord_e.ord < ord_s.ord) begin
         stat_in = STAT_ORDER;
      end else begin
         stat_in = STAT_OK;
         cnt_in  = diff[CountW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         v_ff     <= v_in;
         rsp_v_ff <= v_ff[Stages-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cnt_ff  <= cnt_in;
         stat_ff <= stat_in;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {stat_ff, cnt_ff};

   a_count_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && (stat_ff != STAT_OK) |-> (cnt_ff == '0))
      else $error("nonzero day count with error status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> (stat_ff == STAT_OK || stat_ff == STAT_ORDER ||
                    stat_ff == STAT_INVALID))
      else $error("unused status code on rsp");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && !rsp_tready |=> $stable(v_ff) && $stable(cnt_ff))
      else $error("pipeline moved during stall");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_v_ff && (v_ff == '0))
      else $error("valid bits set after reset");

endmodule
`default_nettype wire
